/* hdl/assert_macros.svh */
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hdl/rclfs_pkg.sv */
package rclfs_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_MAGIC   = 2'd1;
	localparam logic [1:0] CFG_TYPE    = 2'd2;
	localparam logic [1:0] CFG_ARM     = 2'd3;

	// configuration reset values
	localparam logic [15:0] TIMEOUT_RST  = 16'd500;
	localparam logic [7:0]  ARM_MASK_RST = 8'd1;

	// pulse width constants in us
	localparam logic [10:0] PWM_BASE    = 11'd1000;
	localparam logic [10:0] PWM_NEUTRAL = 11'd1500;

	// clamp limits
	localparam logic [7:0]        THR_MAX = 8'd100;
	localparam logic signed [7:0] STR_MAX = 8'sd100;
	localparam logic signed [7:0] STR_MIN = -8'sd100;
	localparam logic [7:0]        STR_OFS = 8'd100;

	// link quality arithmetic
	localparam int unsigned QW       = 32;
	localparam int unsigned QCNT_W   = $clog2(QW);
	localparam logic [QW-1:0] QUAL_SCALE = 32'd100;
	localparam logic [6:0]    PCT_MAX    = 7'd100;

	typedef struct packed {
		logic               action;
		logic               length_ok;
		logic [7:0]         magic;
		logic [7:0]         packet_type;
		logic [15:0]        sequence_req;
		logic [7:0]         throttle;
		logic signed [7:0]  steering;
		logic [7:0]         toggle_count;
		logic [7:0]         flags;
		logic [47:0]        source_address;
	} item_t;

	typedef struct packed {
		logic [10:0] throttle_pwm;
		logic [10:0] steering_pwm;
		logic        arm_cmd_issue;
		logic        arm_cmd_value;
		logic        failsafe_active;
		logic        packet_accepted;
		logic        new_peer;
		logic [6:0]  link_quality;
		logic [31:0] received_count;
		logic [31:0] missed_count;
	} result_t;

	// controller to datapath commands
	typedef struct packed {
		logic update;
		logic mul;
		logic div_start;
		logic load;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_done;
	} ctrl_sts_t;

endpackage

/* hdl/rclfs_div.sv */
module rclfs_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [rclfs_pkg::QW-1:0] num,
	input  logic [rclfs_pkg::QW-1:0] den,
	output logic [rclfs_pkg::QW-1:0] quot,
	output logic                   done
);
	import rclfs_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [QW-1:0]     quo_q;
	logic [QW-1:0]     rem_q;
	logic [QW-1:0]     den_q;

	logic [QW:0]   shifted;
	logic [QW+1:0] diff;
	logic          borrow;

	// one restoring step per cycle
	assign shifted = {rem_q, quo_q[QW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign borrow  = diff[QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == QCNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[QW-2:0], ~borrow};
			rem_q <= borrow ? shifted[QW-1:0] : diff[QW-1:0];
		end
	end

	assign quot = quo_q;
	assign done = done_q;

endmodule

/* hdl/rclfs_ctrl.sv */
module rclfs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	output logic                  result_valid,
	input  logic                  result_stall,
	input  rclfs_pkg::ctrl_sts_t  sts,
	output rclfs_pkg::ctrl_cmd_t  cmd
);
	import rclfs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// output register can take a beat when empty or being drained
	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.update = item_valid;
				if (item_valid) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_START;
			end
			S_START: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_DONE;
			end
			S_DONE: begin
				cmd.load = out_free;
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
		end
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;

endmodule

/* hdl/rclfs_dp.sv */
module rclfs_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  rclfs_pkg::item_t     item,
	input  rclfs_pkg::ctrl_cmd_t cmd,
	output rclfs_pkg::ctrl_sts_t sts,
	output rclfs_pkg::result_t   result
);
	import rclfs_pkg::*;

	// configuration
	logic [15:0] timeout_q;
	logic [7:0]  magic_q;
	logic [7:0]  type_q;
	logic [7:0]  arm_mask_q;

	// link state
	logic [47:0] peer_addr_q;
	logic        peer_known_q;
	logic [15:0] last_seq_q;
	logic [31:0] recv_q;
	logic [31:0] gaps_q;
	logic [15:0] silence_q;
	logic        seen_q;
	logic        failsafe_q;
	logic [7:0]  last_toggle_q;
	logic [10:0] thr_w_q;
	logic [10:0] str_w_q;

	// per-beat flags
	logic issue_q;
	logic value_q;
	logic acc_q;
	logic fresh_q;

	// quality operands
	logic [QW-1:0] num_q;
	logic [QW-1:0] tot_q;
	logic          zero_q;
	logic [QW-1:0] quot;
	logic [QW-1:0] tot_sum;

	result_t result_q;

	logic              pkt_ok;
	logic              sync;
	logic              addr_new;
	logic              seq_gap;
	logic [15:0]       silence_inc;
	logic              timeout_hit;
	logic [6:0]        thr_c;
	logic signed [7:0] st_c;
	logic [7:0]        st_off;
	logic [10:0]       thr_w;
	logic [10:0]       str_w;
	logic              toggle_chg;
	logic              arm_new;
	logic [6:0]        quality;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RST;
			magic_q    <= '0;
			type_q     <= '0;
			arm_mask_q <= ARM_MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TIMEOUT: timeout_q  <= cfg_data;
				CFG_MAGIC:   magic_q    <= cfg_data[7:0];
				CFG_TYPE:    type_q     <= cfg_data[7:0];
				CFG_ARM:     arm_mask_q <= cfg_data[7:0];
				default:     ;
			endcase
		end
	end

	// packet checks and tick timing
	assign pkt_ok = item.action && item.length_ok &&
		(item.magic == magic_q) && (item.packet_type == type_q);
	assign sync        = !seen_q || failsafe_q;
	assign addr_new    = !peer_known_q || (peer_addr_q != item.source_address);
	assign seq_gap     = (recv_q != '0) && (item.sequence_req != last_seq_q + 16'd1);
	assign silence_inc = (silence_q == 16'hFFFF) ? silence_q : silence_q + 16'd1;
	assign timeout_hit = seen_q && (silence_inc > timeout_q) && !failsafe_q;
	assign toggle_chg  = (item.toggle_count != last_toggle_q);
	assign arm_new     = |(item.flags & arm_mask_q);

	// clamp and scale to pulse widths
	assign thr_c  = (item.throttle > THR_MAX) ? THR_MAX[6:0] : item.throttle[6:0];
	always_comb begin
		priority if (item.steering > STR_MAX) st_c = STR_MAX;
		else if (item.steering < STR_MIN) st_c = STR_MIN;
		else st_c = item.steering;
	end
	assign st_off = $unsigned(st_c) + STR_OFS;
	assign thr_w  = PWM_BASE + {1'b0, thr_c, 3'b000} + {3'b000, thr_c, 1'b0};
	assign str_w  = PWM_BASE + {1'b0, st_off, 2'b00} + {3'b000, st_off};

	// state update on each beat taken from the input
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_addr_q   <= '0;
			peer_known_q  <= 1'b0;
			last_seq_q    <= '0;
			recv_q        <= '0;
			gaps_q        <= '0;
			silence_q     <= '0;
			seen_q        <= 1'b0;
			failsafe_q    <= 1'b0;
			last_toggle_q <= '0;
			thr_w_q       <= PWM_BASE;
			str_w_q       <= PWM_NEUTRAL;
			issue_q       <= 1'b0;
			value_q       <= 1'b0;
			acc_q         <= 1'b0;
			fresh_q       <= 1'b0;
		end else if (cmd.update) begin
			issue_q <= 1'b0;
			value_q <= 1'b0;
			acc_q   <= 1'b0;
			fresh_q <= 1'b0;
			if (!item.action) begin
				silence_q <= silence_inc;
				if (timeout_hit) begin
					thr_w_q    <= PWM_BASE;
					str_w_q    <= PWM_NEUTRAL;
					failsafe_q <= 1'b1;
					issue_q    <= 1'b1;
				end
			end else if (pkt_ok) begin
				acc_q <= 1'b1;
				if (addr_new) begin
					peer_addr_q  <= item.source_address;
					peer_known_q <= 1'b1;
					fresh_q      <= 1'b1;
				end
				if (seq_gap) gaps_q <= gaps_q + 32'd1;
				last_seq_q <= item.sequence_req;
				recv_q     <= recv_q + 32'd1;
				silence_q  <= '0;
				seen_q     <= 1'b1;
				thr_w_q    <= thr_w;
				str_w_q    <= str_w;
				if (sync) begin
					// resync only, no command
					last_toggle_q <= item.toggle_count;
					failsafe_q    <= 1'b0;
				end else if (toggle_chg) begin
					last_toggle_q <= item.toggle_count;
					issue_q       <= 1'b1;
					value_q       <= arm_new;
				end
			end
		end
	end

	// quality operands, product registered before the divider
	assign tot_sum = recv_q + gaps_q;
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			num_q  <= recv_q * QUAL_SCALE;
			tot_q  <= tot_sum;
			zero_q <= (tot_sum == '0);
		end
	end

	rclfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_q),
		.den    (tot_q),
		.quot   (quot),
		.done   (sts.div_done)
	);

	// percent, capped
	always_comb begin
		priority if (zero_q) quality = '0;
		else if (quot > QW'(PCT_MAX)) quality = PCT_MAX;
		else quality = quot[6:0];
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			result_q.throttle_pwm    <= thr_w_q;
			result_q.steering_pwm    <= str_w_q;
			result_q.arm_cmd_issue   <= issue_q;
			result_q.arm_cmd_value   <= issue_q && value_q;
			result_q.failsafe_active <= failsafe_q;
			result_q.packet_accepted <= acc_q;
			result_q.new_peer        <= fresh_q;
			result_q.link_quality    <= quality;
			result_q.received_count  <= recv_q;
			result_q.missed_count    <= gaps_q;
		end
	end

	assign result = result_q;

endmodule

/* hdl/rc_link_failsafe_receiver.sv */
// Radio-control link receiver with link-loss failsafe.
// Input channel (item_valid / item_stall / item): one beat is either a 1 ms
// tick or a received control packet; a beat is taken when item_valid is high
// and item_stall is low.
// Output channel (result_valid / result_stall / result): exactly one result
// beat per input beat, in order, with pulse widths, arm command, failsafe
// flag, packet flags, link quality percent and the wrapping counters.
// Configuration: cfg_we writes cfg_data into register cfg_index (timeout,
// magic, type, arm mask); write only while no beat is in flight.
// Each beat passes through the states update, multiply, divider start, divide
// and load before its result is registered; a new beat is not taken while one
// is in flight. Link quality uses the bit-per-cycle 32-bit divider.
// The input is taken again as soon as a result is in the output register;
// if the receiver stalls, the block holds its next result and the input
// waits until the output register frees.
// Reset (arst_n low): configuration returns to its defaults, counters,
// peer and failsafe state clear, widths go to 1000 / 1500 us, no result.
`include "assert_macros.svh"

module rc_link_failsafe_receiver (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic                item_valid,
	output logic                item_stall,
	input  rclfs_pkg::item_t    item,
	output logic                result_valid,
	input  logic                result_stall,
	output rclfs_pkg::result_t  result
);
	import rclfs_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	rclfs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	rclfs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

	// busy right after taking a beat
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, item_valid && !item_stall, item_stall, "input not stalled after beat taken")
	// quality never above 100 percent
	`ASSERT_ALWAYS(a_quality_cap, clk, arst_n, !result_valid || (result.link_quality <= PCT_MAX), "link quality above cap")
	// new peer only on an accepted packet
	`ASSERT_ALWAYS(a_peer_on_accept, clk, arst_n, !result_valid || !result.new_peer || result.packet_accepted, "new peer without accepted packet")
	// arm value only with a command
	`ASSERT_ALWAYS(a_arm_value, clk, arst_n, !result_valid || !result.arm_cmd_value || result.arm_cmd_issue, "arm value without command")

endmodule

/* bench/rc_link_failsafe_receiver_tb.sv */
module rc_link_failsafe_receiver_tb;
	import rclfs_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 40;
	localparam int N_PHASES     = 8;
	localparam int PHASE_BEATS  = 190;

	typedef struct {
		logic        cfg_on;
		logic [1:0]  cfg_idx;
		logic [15:0] cfg_val;
		item_t       beat;
		logic        typed;
		result_t     want;
	} plan_row_t;

	typedef struct {
		logic [15:0] tmo;
		logic [7:0]  mg;
		logic [7:0]  ty;
		logic [7:0]  am;
	} setting_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_TIMEOUT;
	logic [15:0] cfg_data = 16'd0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;

	// shadow of the configuration registers
	logic [15:0] cf_timeout = TIMEOUT_RST;
	logic [7:0]  cf_magic = 8'd0;
	logic [7:0]  cf_type = 8'd0;
	logic [7:0]  cf_mask = ARM_MASK_RST;

	// shadow of the link state
	logic [47:0] lk_peer = '0;
	logic        lk_peer_known = 1'b0;
	logic [15:0] lk_last_seq = '0;
	logic [31:0] lk_rcv = '0;
	logic [31:0] lk_gaps = '0;
	logic [15:0] lk_silence = '0;
	logic        lk_seen = 1'b0;
	logic        lk_fs = 1'b0;
	logic [7:0]  lk_last_tog = '0;
	logic        lk_arm = 1'b0;
	logic [10:0] lk_thr_w = PWM_BASE;
	logic [10:0] lk_str_w = PWM_NEUTRAL;

	// stimulus generator state
	logic [15:0] gen_seq = '0;
	logic [7:0]  gen_toggle = '0;
	logic [47:0] gen_peers [2];

	result_t   expected_status [$];
	result_t   want_r;
	plan_row_t plan [$];
	setting_t  phases [N_PHASES];
	result_t   idle_res;
	logic      calm = 1'b0;
	int        fails = 0;
	int        cycle_count = 0;

	rc_link_failsafe_receiver uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic item_t mk_tick();
		item_t it;
		it = '0;
		it.flags = 8'($urandom);
		it.source_address = 48'({$urandom, $urandom});
		return it;
	endfunction

	function automatic item_t mk_pkt(input logic len, input logic [7:0] mg, input logic [7:0] ty,
			input logic [15:0] seq, input logic [7:0] thr, input logic signed [7:0] st,
			input logic [7:0] tc, input logic [7:0] fl, input logic [47:0] addr);
		item_t it;
		it.action = 1'b1;
		it.length_ok = len;
		it.magic = mg;
		it.packet_type = ty;
		it.sequence_req = seq;
		it.throttle = thr;
		it.steering = st;
		it.toggle_count = tc;
		it.flags = fl;
		it.source_address = addr;
		return it;
	endfunction

	function automatic result_t mk_status(input logic [10:0] thr, input logic [10:0] str,
			input logic iss, input logic val, input logic fs, input logic acc, input logic np,
			input logic [6:0] lq, input logic [31:0] rc, input logic [31:0] mc);
		result_t r;
		r.throttle_pwm = thr;
		r.steering_pwm = str;
		r.arm_cmd_issue = iss;
		r.arm_cmd_value = val;
		r.failsafe_active = fs;
		r.packet_accepted = acc;
		r.new_peer = np;
		r.link_quality = lq;
		r.received_count = rc;
		r.missed_count = mc;
		return r;
	endfunction

	// advance the link state by one beat and return the status it shows
	function automatic result_t next_link_status(input item_t it);
		logic        issue, arm_v, taken, fresh, resync;
		logic [15:0] seq_next;
		int          thr_c, st_c;
		logic [31:0] sum, pct;
		issue = 1'b0;
		arm_v = 1'b0;
		taken = 1'b0;
		fresh = 1'b0;
		if (!it.action) begin
			// tick: count silence, trip failsafe once
			if (lk_silence != 16'hFFFF)
				lk_silence = lk_silence + 16'd1;
			if (lk_seen && lk_silence > cf_timeout && !lk_fs) begin
				lk_thr_w = PWM_BASE;
				lk_str_w = PWM_NEUTRAL;
				lk_arm = 1'b0;
				lk_fs = 1'b1;
				issue = 1'b1;
			end
		end else if (it.length_ok && it.magic == cf_magic && it.packet_type == cf_type) begin
			resync = !lk_seen || lk_fs;
			taken = 1'b1;
			if (!lk_peer_known || lk_peer != it.source_address) begin
				lk_peer = it.source_address;
				lk_peer_known = 1'b1;
				fresh = 1'b1;
			end
			seq_next = lk_last_seq + 16'd1;
			if (lk_rcv != 32'd0 && it.sequence_req != seq_next)
				lk_gaps = lk_gaps + 32'd1;
			lk_last_seq = it.sequence_req;
			lk_rcv = lk_rcv + 32'd1;
			lk_silence = 16'd0;
			lk_seen = 1'b1;
			// clamp and map to pulse widths
			thr_c = (it.throttle > 8'd100) ? 100 : int'(it.throttle);
			st_c = int'(it.steering);
			if (st_c > 100)
				st_c = 100;
			if (st_c < -100)
				st_c = -100;
			lk_thr_w = 11'(1000 + thr_c * 10);
			lk_str_w = 11'(1000 + (st_c + 100) * 5);
			// arm toggle tracking
			if (resync) begin
				lk_last_tog = it.toggle_count;
				lk_arm = 1'b0;
				lk_fs = 1'b0;
			end else if (it.toggle_count != lk_last_tog) begin
				lk_last_tog = it.toggle_count;
				lk_arm = (it.flags & cf_mask) != 8'd0;
				issue = 1'b1;
				arm_v = lk_arm;
			end
		end
		// link quality percent
		sum = lk_rcv + lk_gaps;
		if (sum == 32'd0) begin
			pct = 32'd0;
		end else begin
			pct = (lk_rcv * 32'd100) / sum;
			if (pct > 32'd100)
				pct = 32'd100;
		end
		return mk_status(lk_thr_w, lk_str_w, issue, issue && arm_v, lk_fs, taken, fresh,
			7'(pct), lk_rcv, lk_gaps);
	endfunction

	// random control packet, well formed or broken
	function automatic item_t rand_packet(input logic good);
		item_t it;
		int    pick, st_i;
		it.action = 1'b1;
		it.length_ok = 1'b1;
		it.magic = cf_magic;
		it.packet_type = cf_type;
		if (!good) begin
			pick = $urandom_range(2);
			case (pick)
				0: it.length_ok = 1'b0;
				1: it.magic = 8'($urandom);
				default: it.packet_type = 8'($urandom);
			endcase
		end
		if ($urandom_range(99) < 85)
			gen_seq = gen_seq + 16'd1;
		else
			gen_seq = 16'($urandom);
		it.sequence_req = gen_seq;
		if ($urandom_range(99) < 70)
			it.throttle = 8'($urandom_range(100));
		else
			it.throttle = 8'($urandom);
		if ($urandom_range(99) < 70) begin
			st_i = $urandom_range(200);
			it.steering = 8'(st_i - 100);
		end else begin
			it.steering = 8'($urandom);
		end
		if ($urandom_range(99) < 35)
			gen_toggle = ($urandom_range(1)) ? gen_toggle + 8'd1 : 8'($urandom);
		it.toggle_count = gen_toggle;
		it.flags = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 80)
			it.source_address = gen_peers[0];
		else if (pick < 90)
			it.source_address = gen_peers[1];
		else
			it.source_address = 48'({$urandom, $urandom});
		return it;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	// offer one input beat and record what it should produce
	task automatic drive_beat(input item_t it, input logic typed, input result_t want);
		result_t predicted;
		while (!calm && $urandom_range(99) < 23) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
		predicted = next_link_status(it);
		expected_status.push_back(typed ? want : predicted);
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain_results();
		item_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TIMEOUT: cf_timeout = val;
			CFG_MAGIC:   cf_magic = val[7:0];
			CFG_TYPE:    cf_type = val[7:0];
			CFG_ARM:     cf_mask = val[7:0];
			default: ;
		endcase
	endtask

	// result side: random stall and in-order compare
	always @(posedge clk) begin
		result_stall <= !calm && ($urandom_range(99) < 23);
		if (arst_n && result_valid && !result_stall) begin
			if (expected_status.size() == 0) begin
				$error("result beat with nothing expected");
				fails++;
			end else begin
				want_r = expected_status.pop_front();
				check_field("throttle_pwm", want_r.throttle_pwm, result.throttle_pwm);
				check_field("steering_pwm", want_r.steering_pwm, result.steering_pwm);
				check_field("arm_cmd_issue", want_r.arm_cmd_issue, result.arm_cmd_issue);
				check_field("arm_cmd_value", want_r.arm_cmd_value, result.arm_cmd_value);
				check_field("failsafe_active", want_r.failsafe_active, result.failsafe_active);
				check_field("packet_accepted", want_r.packet_accepted, result.packet_accepted);
				check_field("new_peer", want_r.new_peer, result.new_peer);
				check_field("link_quality", want_r.link_quality, result.link_quality);
				check_field("received_count", want_r.received_count, result.received_count);
				check_field("missed_count", want_r.missed_count, result.missed_count);
			end
		end
	end

	initial begin
		int   ph, sent, roll, burst;
		logic paused;
		paused = 1'b0;
		gen_peers[0] = 48'({$urandom, $urandom});
		gen_peers[1] = 48'({$urandom, $urandom});
		idle_res = mk_status(PWM_BASE, PWM_NEUTRAL, 0, 0, 0, 0, 0, 7'd0, 32'd0, 32'd0);

		// directed rows under reset configuration
		plan.push_back('{0, CFG_TIMEOUT, 16'd0, mk_tick(), 1, idle_res});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0,
			mk_pkt(0, 8'h00, 8'h00, 16'd0, 8'd50, 8'sd0, 8'd0, 8'h00, 48'd0), 1, idle_res});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0,
			mk_pkt(1, 8'hFF, 8'h00, 16'd0, 8'd50, 8'sd0, 8'd0, 8'h00, 48'd0), 1, idle_res});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0,
			mk_pkt(1, 8'h00, 8'hFF, 16'd0, 8'd50, 8'sd0, 8'd0, 8'h00, 48'd0), 1, idle_res});
		// first packet only resyncs, raw extremes clamp
		plan.push_back('{0, CFG_TIMEOUT, 16'd0,
			mk_pkt(1, 8'h00, 8'h00, 16'h0000, 8'd255, -8'sd128, 8'd5, 8'hFF, 48'hFFFF_FFFF_FFFF),
			1, mk_status(11'd2000, 11'd1000, 0, 0, 0, 1, 1, 7'd100, 32'd1, 32'd0)});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0,
			mk_pkt(1, 8'h00, 8'h00, 16'h0001, 8'd100, 8'sd127, 8'd6, 8'h01, 48'hFFFF_FFFF_FFFF),
			1, mk_status(11'd2000, 11'd2000, 1, 1, 0, 1, 0, 7'd100, 32'd2, 32'd0)});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0,
			mk_pkt(1, 8'h00, 8'h00, 16'h0005, 8'd0, 8'sd0, 8'd7, 8'hFE, 48'd0),
			1, mk_status(11'd1000, 11'd1500, 1, 0, 0, 1, 1, 7'd75, 32'd3, 32'd1)});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0,
			mk_pkt(1, 8'h00, 8'h00, 16'h0006, 8'd101, -8'sd101, 8'd7, 8'h01, 48'd0), 0, idle_res});
		// sequence wrap from 0xffff to 0
		plan.push_back('{0, CFG_TIMEOUT, 16'd0,
			mk_pkt(1, 8'h00, 8'h00, 16'hFFFF, 8'd50, 8'sd100, 8'd7, 8'h00, 48'd0), 0, idle_res});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0,
			mk_pkt(1, 8'h00, 8'h00, 16'h0000, 8'd99, -8'sd100, 8'd8, 8'h01, 48'd1), 0, idle_res});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0,
			mk_pkt(1, 8'h00, 8'h00, 16'h0001, 8'd1, -8'sd127, 8'd9, 8'hAA, 48'd1), 0, idle_res});
		// failsafe after a short silence, then resync
		plan.push_back('{1, CFG_TIMEOUT, 16'd2, mk_tick(), 0, idle_res});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0, mk_tick(), 0, idle_res});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0, mk_tick(), 0, idle_res});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0, mk_tick(), 0, idle_res});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0,
			mk_pkt(1, 8'h00, 8'h00, 16'h0002, 8'd30, 8'sd20, 8'h55, 8'hFF, 48'd1), 0, idle_res});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0,
			mk_pkt(1, 8'h00, 8'h00, 16'h0003, 8'd40, -8'sd20, 8'h56, 8'h01, 48'd1), 0, idle_res});
		// arm mask on the top bit
		plan.push_back('{1, CFG_ARM, 16'h0080,
			mk_pkt(1, 8'h00, 8'h00, 16'h0004, 8'd60, 8'sd50, 8'h57, 8'h7F, 48'd1), 0, idle_res});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0,
			mk_pkt(1, 8'h00, 8'h00, 16'h0005, 8'd70, -8'sd50, 8'h58, 8'h80, 48'd1), 0, idle_res});
		// zero timeout trips on the first tick
		plan.push_back('{1, CFG_TIMEOUT, 16'd0, mk_tick(), 0, idle_res});
		plan.push_back('{1, CFG_MAGIC, 16'h00A5,
			mk_pkt(1, 8'h00, 8'h00, 16'h0006, 8'd10, 8'sd10, 8'h59, 8'h01, 48'd1), 0, idle_res});
		plan.push_back('{1, CFG_TYPE, 16'h003C,
			mk_pkt(1, 8'hA5, 8'h3C, 16'h0009, 8'd20, 8'sd30, 8'h5A, 8'h81, 48'd2), 0, idle_res});
		// maximum timeout never trips
		plan.push_back('{1, CFG_TIMEOUT, 16'hFFFF, mk_tick(), 0, idle_res});
		plan.push_back('{0, CFG_TIMEOUT, 16'd0, mk_tick(), 0, idle_res});

		// settings for the random phases
		phases[0] = '{16'd1, 8'h00, 8'h00, 8'h01};
		phases[1] = '{16'hFFFF, 8'hFF, 8'hFF, 8'hFF};
		phases[2] = '{16'd2, 8'hFF, 8'h00, 8'h00};
		phases[3] = '{16'd500, 8'h5A, 8'h81, 8'h02};
		for (ph = 4; ph < N_PHASES; ph++)
			phases[ph] = '{16'($urandom_range(1, 16)), 8'($urandom), 8'($urandom),
				8'($urandom)};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[k]) begin
			if (plan[k].cfg_on)
				write_reg(plan[k].cfg_idx, plan[k].cfg_val);
			drive_beat(plan[k].beat, plan[k].typed, plan[k].want);
		end

		// random phases
		for (ph = 0; ph < N_PHASES; ph++) begin
			write_reg(CFG_TIMEOUT, phases[ph].tmo);
			write_reg(CFG_MAGIC, {8'd0, phases[ph].mg});
			write_reg(CFG_TYPE, {8'd0, phases[ph].ty});
			write_reg(CFG_ARM, {8'd0, phases[ph].am});
			calm <= (ph == 5);
			sent = 0;
			while (sent < PHASE_BEATS) begin
				if (ph == 4 && sent >= 90 && !paused) begin
					drain_results();
					paused = 1'b1;
				end
				roll = $urandom_range(99);
				if (roll < 30) begin
					// silence long enough to reach the timeout when it is short
					if (cf_timeout <= 16'd16)
						burst = $urandom_range(1, int'(cf_timeout) + 3);
					else
						burst = $urandom_range(1, 5);
					repeat (burst) begin
						drive_beat(mk_tick(), 1'b0, idle_res);
						sent++;
					end
				end else begin
					drive_beat(rand_packet(roll < 88), 1'b0, idle_res);
					sent++;
				end
			end
		end

		calm <= 1'b0;
		drain_results();
		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
